@@ src/rtpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtpc_pkg
// Types and constants shared by the radio transmit pacing controller.
// ----------------------------------------------------------------------------
package rtpc_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FILL_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int PERIOD_W    = 16;
    localparam int INTERVAL_W  = 4;
    localparam int WAIT_W      = 32;
    localparam int OUT_TDATA_W = 40;

    // window period divided by a shortfall of up to 17 bits: one quotient bit per step
    localparam int DIV_STEPS   = PERIOD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int SHORT_W     = 17;

    localparam int BUFFER_DEPTH_DEF = 255;

    localparam logic [FILL_W-1:0]     MIN_TX_COUNT_RST    = 8'd30;
    localparam logic [FILL_W-1:0]     BASE_TARGET_RST     = 8'd5;
    localparam logic [PERIOD_W-1:0]   WINDOW_PERIOD_RST   = 16'd1000;
    localparam logic [INTERVAL_W-1:0] RETUNE_INTERVAL_RST = 4'd3;
    localparam logic [FILL_W-1:0]     MIN_FILL_START_RST  = 8'd255;

    localparam logic [WAIT_W-1:0]  WAIT_NO_PACE = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_TX_COUNT    = 3'd0,
        CFG_BASE_TARGET     = 3'd1,
        CFG_WINDOW_PERIOD   = 3'd2,
        CFG_RETUNE_INTERVAL = 3'd3,
        CFG_MIN_FILL_START  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        FUNC_PKT_SENT = 1'b0,
        FUNC_WIN_DONE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

@@ src/radio_tx_pacing_controller.sv @@
// ----------------------------------------------------------------------------
// radio_tx_pacing_controller
// Paces packet production per radio window from buffer fill events.
// ----------------------------------------------------------------------------
// channel   direction  tdata                              tuser
// s_axis    in         [7:0] buffer_fill                  [0] func
// m_axis    out        [31:0] pace_wait, [39:32] target   -
// cfg       in         write enable, index, 16-bit data   -
//
// a packet-sent event is handled in idle; a window event with no pacing goes
// straight to done, one that needs a wait period first runs 16 restoring divide
// steps on one shared subtract/compare unit, between load and hand-off
// reset is synchronous, active low, and restores configuration, window state
// and the output valid; divider remainder, quotient, divisor and output data registers are not reset
// a stalled result stays in the output register; the next item is still
// accepted, but a new result waits in the done state until that one is taken
// ----------------------------------------------------------------------------
module radio_tx_pacing_controller
    import rtpc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [FILL_W-1:0]      s_axis_tdata,   // [7:0] buffer_fill
    input  logic                   s_axis_tuser,   // [0] func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] pace_wait, [39:32] buffer_target
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int TargetLimit = (BUFFER_DEPTH > 255) ? 255 : BUFFER_DEPTH;
    localparam logic [9:0] TARGET_LIM = 10'(TargetLimit);

    // configuration
    logic [FILL_W-1:0]     r_min_tx_count;
    logic [FILL_W-1:0]     r_base_target;
    logic [PERIOD_W-1:0]   r_window_period;
    logic [INTERVAL_W-1:0] r_retune_interval;
    logic [FILL_W-1:0]     r_min_fill_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_tx_count    <= MIN_TX_COUNT_RST;
            r_base_target     <= BASE_TARGET_RST;
            r_window_period   <= WINDOW_PERIOD_RST;
            r_retune_interval <= RETUNE_INTERVAL_RST;
            r_min_fill_start  <= MIN_FILL_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_TX_COUNT:    r_min_tx_count    <= i_cfg_wdata[FILL_W-1:0];
                CFG_BASE_TARGET:     r_base_target     <= i_cfg_wdata[FILL_W-1:0];
                CFG_WINDOW_PERIOD:   r_window_period   <= i_cfg_wdata;
                CFG_RETUNE_INTERVAL: r_retune_interval <= i_cfg_wdata[INTERVAL_W-1:0];
                CFG_MIN_FILL_START:  r_min_fill_start  <= i_cfg_wdata[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    // state
    t_state r_state, n_state;

    logic [COUNT_W-1:0]    r_sent_count,     n_sent_count;
    logic [FILL_W-1:0]     r_lowest_fill,    n_lowest_fill;
    logic [FILL_W-1:0]     r_target_fill,    n_target_fill;
    logic [INTERVAL_W-1:0] r_window_counter, n_window_counter;

    logic [SHORT_W-1:0]    r_rem,     n_rem;
    logic [PERIOD_W-1:0]   r_quot,    n_quot;
    logic [SHORT_W-1:0]    r_divisor, n_divisor;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic                  r_no_pace, n_no_pace;

    logic                   r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data,  n_m_data;

    logic in_xact;
    logic out_free;
    logic div_last;
    logic win_event;

    assign in_xact  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign div_last = (r_div_cnt == DIV_CNT_W'(1));
    assign win_event = (s_axis_tuser == FUNC_WIN_DONE);

    // window arithmetic
    logic [COUNT_W-1:0] tx;
    logic signed [17:0] expected;
    logic signed [17:0] shortfall;
    logic               no_pace;
    logic signed [9:0]  retune_sum;
    logic [FILL_W-1:0]  retune_val;

    always_comb begin
        tx        = (r_sent_count > COUNT_W'(r_min_tx_count)) ? r_sent_count
                                                              : COUNT_W'(r_min_tx_count);
        expected  = $signed({10'b0, s_axis_tdata}) - $signed({2'b0, tx});
        no_pace   = (expected >= $signed({10'b0, r_target_fill}));
        shortfall = $signed({10'b0, r_target_fill}) - expected;
        retune_sum = $signed({2'b0, r_target_fill}) + $signed({2'b0, r_base_target})
                   - $signed({2'b0, r_lowest_fill});
        if (retune_sum[9]) begin
            retune_val = '0;
        end else if (retune_sum > $signed(TARGET_LIM)) begin
            retune_val = TARGET_LIM[FILL_W-1:0];
        end else begin
            retune_val = retune_sum[FILL_W-1:0];
        end
    end

    // shared subtract/compare unit for the restoring divider
    logic [SHORT_W:0] div_shift;
    logic [SHORT_W:0] div_diff;
    assign div_shift = {r_rem, r_quot[PERIOD_W-1]};
    assign div_diff  = div_shift - {1'b0, r_divisor};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xact && win_event) begin
                    n_state = no_pace ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_axis_tready    = (r_state == ST_IDLE);
        n_sent_count     = r_sent_count;
        n_lowest_fill    = r_lowest_fill;
        n_target_fill    = r_target_fill;
        n_window_counter = r_window_counter;
        n_rem            = r_rem;
        n_quot           = r_quot;
        n_divisor        = r_divisor;
        n_div_cnt        = r_div_cnt;
        n_no_pace        = r_no_pace;
        n_m_valid        = r_m_valid && !m_axis_tready;
        n_m_data         = r_m_data;
        case (r_state)
            ST_IDLE: begin
                if (in_xact && !win_event) begin
                    if (r_sent_count != COUNT_MAX) begin
                        n_sent_count = r_sent_count + COUNT_W'(1);
                    end
                    if (s_axis_tdata < r_lowest_fill) begin
                        n_lowest_fill = s_axis_tdata;
                    end
                end else if (in_xact) begin
                    n_sent_count = '0;
                    n_no_pace    = no_pace;
                    n_rem        = '0;
                    n_quot       = r_window_period;
                    n_divisor    = shortfall[SHORT_W-1:0];
                    n_div_cnt    = DIV_CNT_W'(DIV_STEPS);
                    if (r_window_counter < r_retune_interval) begin
                        n_window_counter = r_window_counter + INTERVAL_W'(1);
                    end else begin
                        n_target_fill    = retune_val;
                        n_window_counter = '0;
                        n_lowest_fill    = r_min_fill_start;
                    end
                end
            end
            ST_DIV: begin
                n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
                if (!div_diff[SHORT_W]) begin
                    n_rem  = div_diff[SHORT_W-1:0];
                    n_quot = {r_quot[PERIOD_W-2:0], 1'b1};
                end else begin
                    n_rem  = div_shift[SHORT_W-1:0];
                    n_quot = {r_quot[PERIOD_W-2:0], 1'b0};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_target_fill,
                                 r_no_pace ? WAIT_NO_PACE : WAIT_W'(r_quot)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_sent_count     <= '0;
            r_lowest_fill    <= MIN_FILL_START_RST;
            r_target_fill    <= BASE_TARGET_RST;
            r_window_counter <= '0;
            r_div_cnt        <= '0;
            r_no_pace        <= 1'b0;
            r_m_valid        <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_sent_count     <= n_sent_count;
            r_lowest_fill    <= n_lowest_fill;
            r_target_fill    <= n_target_fill;
            r_window_counter <= n_window_counter;
            r_div_cnt        <= n_div_cnt;
            r_no_pace        <= n_no_pace;
            r_m_valid        <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        r_divisor <= n_divisor;
        r_m_data  <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

@@ sim/radio_tx_pacing_controller_tb.sv @@
// ----------------------------------------------------------------------------
// radio_tx_pacing_controller_tb
// Self-checking bench for the transmit pacing controller. A directed table
// opens the run, then register settings are swept phase by phase with random
// packet/window event streams, ending with a short run at a zero packet floor.
// Every result is compared against an in-bench pacing predictor, or against the table's expected result for typed rows.
// ----------------------------------------------------------------------------
module radio_tx_pacing_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtpc_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RST_CYCLES     = 9;
    localparam int QUIET_CYCLES   = 40;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS    = 200;
    localparam int REPORT_MAX     = 10;
    localparam int TIMEOUT_NS     = 8_000_000;
    localparam int FILL_MAX       = (1 << FILL_W) - 1;
    localparam int TARGET_CAP     = (BUFFER_DEPTH_DEF > FILL_MAX) ? FILL_MAX : BUFFER_DEPTH_DEF;
    localparam int CFG_IDX_SPARE  = int'(CFG_MIN_FILL_START) + 1;
    localparam int CFG_IDX_TOP    = (1 << CFG_IDX_W) - 1;

    typedef struct packed {
        logic [FILL_W-1:0] buffer_target;
        logic [WAIT_W-1:0] pace_wait;
    } t_pace_res;

    typedef struct packed {
        t_func             func;
        logic [FILL_W-1:0] fill;
        logic              typed;
        t_pace_res         res;
    } t_dir_row;

    typedef struct packed {
        logic [FILL_W-1:0]     min_tx;
        logic [FILL_W-1:0]     base;
        logic [PERIOD_W-1:0]   period;
        logic [INTERVAL_W-1:0] interval;
        logic [FILL_W-1:0]     fill_start;
        logic                  hold_rx;
        logic                  calm;
    } t_settings;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY3
    } t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [FILL_W-1:0]      s_axis_tdata;   // [7:0] buffer_fill
    logic                   s_axis_tuser;   // [0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] pace_wait, [39:32] buffer_target
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    // typed expectation that travels with the directed rows
    logic      row_typed;
    t_pace_res row_res;

    // register mirror
    logic [FILL_W-1:0]     cfg_min_tx;
    logic [FILL_W-1:0]     cfg_base;
    logic [PERIOD_W-1:0]   cfg_period;
    logic [INTERVAL_W-1:0] cfg_interval;
    logic [FILL_W-1:0]     cfg_fill_start;

    // pacing state
    logic [COUNT_W-1:0]    pace_sent;
    logic [FILL_W-1:0]     pace_low;
    logic [FILL_W-1:0]     pace_target;
    logic [INTERVAL_W-1:0] pace_win_cnt;

    t_pace_res pending_pace[$];

    int  mismatches;
    int  results_seen;
    int  pkt_events;
    int  win_events;
    int  paced_windows;
    int  free_windows;
    int  retunes;
    int  rx_holds;
    int  burst_left;
    bit  sender_calm;
    bit  rx_hold_req;

    t_dir_row dir_rows [20] = '{
        '{FUNC_WIN_DONE, 8'd255, 1'b1, '{8'd5, WAIT_NO_PACE}},
        '{FUNC_WIN_DONE, 8'd0,   1'b1, '{8'd5, 32'd28}},
        '{FUNC_PKT_SENT, 8'd0,   1'b0, '{8'd0, 32'd0}},
        '{FUNC_PKT_SENT, 8'd255, 1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd35,  1'b1, '{8'd5, WAIT_NO_PACE}},
        '{FUNC_WIN_DONE, 8'd34,  1'b1, '{8'd10, 32'd1000}},
        '{FUNC_PKT_SENT, 8'd128, 1'b0, '{8'd0, 32'd0}},
        '{FUNC_PKT_SENT, 8'd1,   1'b0, '{8'd0, 32'd0}},
        '{FUNC_PKT_SENT, 8'd254, 1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd0,   1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd40,  1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd39,  1'b0, '{8'd0, 32'd0}},
        '{FUNC_PKT_SENT, 8'd255, 1'b0, '{8'd0, 32'd0}},
        '{FUNC_PKT_SENT, 8'd0,   1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd128, 1'b0, '{8'd0, 32'd0}},
        '{FUNC_PKT_SENT, 8'd85,  1'b0, '{8'd0, 32'd0}},
        '{FUNC_PKT_SENT, 8'd170, 1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd255, 1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd1,   1'b0, '{8'd0, 32'd0}},
        '{FUNC_WIN_DONE, 8'd254, 1'b0, '{8'd0, 32'd0}}
    };

    t_settings sweep_plan [4] = '{
        // smallest values but a unit period, retune on every window
        '{8'd0,   8'd0,   16'd1,      4'd0,  8'd0,   1'b0, 1'b0},
        '{8'd255, 8'd255, 16'hFFFF,   4'd15, 8'd255, 1'b1, 1'b0},
        // zero period; interval lowered below the running window count
        '{8'd30,  8'd0,   16'd0,      4'd2,  8'd255, 1'b0, 1'b1},
        '{8'd0,   8'd255, 16'd1000,   4'd1,  8'd0,   1'b1, 1'b0}
    };

    radio_tx_pacing_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_pace.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void pacing_reset();
        cfg_min_tx     = MIN_TX_COUNT_RST;
        cfg_base       = BASE_TARGET_RST;
        cfg_period     = WINDOW_PERIOD_RST;
        cfg_interval   = RETUNE_INTERVAL_RST;
        cfg_fill_start = MIN_FILL_START_RST;
        pace_sent      = '0;
        pace_low       = cfg_fill_start;
        pace_target    = cfg_base;
        pace_win_cnt   = '0;
    endfunction

    function automatic void pace_event(input t_func f, input logic [FILL_W-1:0] fill,
                                       output bit emits, output t_pace_res res);
        int tx;
        int est;
        int shortfall;
        int retarget;
        res   = '0;
        emits = 1'b0;
        if (f == FUNC_PKT_SENT) begin
            pkt_events++;
            if (pace_sent != COUNT_MAX)
                pace_sent++;
            if (fill < pace_low)
                pace_low = fill;
            return;
        end
        win_events++;
        tx  = (int'(pace_sent) > int'(cfg_min_tx)) ? int'(pace_sent) : int'(cfg_min_tx);
        est = int'(fill) - tx;
        if (est >= int'(pace_target)) begin
            res.pace_wait = WAIT_NO_PACE;
            free_windows++;
        end else begin
            shortfall     = int'(pace_target) - est;
            res.pace_wait = WAIT_W'(cfg_period) / WAIT_W'(shortfall);
            paced_windows++;
        end
        pace_sent = '0;
        if (pace_win_cnt < cfg_interval) begin
            pace_win_cnt++;
        end else begin
            retarget = int'(pace_target) + int'(cfg_base) - int'(pace_low);
            if (retarget < 0)
                retarget = 0;
            if (retarget > TARGET_CAP)
                retarget = TARGET_CAP;
            pace_target  = FILL_W'(retarget);
            pace_win_cnt = '0;
            pace_low     = cfg_fill_start;
            retunes++;
        end
        res.buffer_target = pace_target;
        emits = 1'b1;
    endfunction

    task automatic check_result(input t_pace_res got);
        t_pace_res want;
        results_seen++;
        if (pending_pace.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: result with nothing expected: wait %h target %0d",
                         $realtime, got.pace_wait, got.buffer_target);
            return;
        end
        want = pending_pace.pop_front();
        if (got.pace_wait !== want.pace_wait || got.buffer_target !== want.buffer_target) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: mismatch wait exp %h got %h, target exp %0d got %0d",
                         $realtime, want.pace_wait, got.pace_wait,
                         want.buffer_target, got.buffer_target);
        end
    endtask

    // output is checked before the new input is predicted, so a result
    // leaving on the same edge always matches an older transaction
    always @(posedge i_clk) begin : scoreboard
        t_pace_res want;
        bit        emits;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                pace_event(t_func'(s_axis_tuser), s_axis_tdata, emits, want);
                if (emits)
                    pending_pace.push_back(row_typed ? row_res : want);
            end
        end
    end

    initial begin : receiver
        t_rx_mode mode;
        int       left;
        m_axis_tready = 1'b0;
        mode          = RX_OPEN;
        left          = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_holds++;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= (left % 3 == 0);
                endcase
            end
        end
    end

    // called at a falling edge; tvalid stays high across a burst
    task automatic send_event(input t_func f, input logic [FILL_W-1:0] fill,
                              input logic typed, input t_pace_res res);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = 0;
            if (!sender_calm && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= fill;
        row_typed     <= typed;
        row_res       <= res;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending_pace.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= d;
        @(negedge i_clk);
    endtask

    // unused upper data bits carry junk; one write goes to an unmapped index
    task automatic apply_settings(input t_settings s);
        cfg_write(CFG_MIN_TX_COUNT, {8'($urandom), s.min_tx});
        cfg_write(CFG_BASE_TARGET, {8'($urandom), s.base});
        cfg_write(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP)), 16'($urandom));
        cfg_write(CFG_WINDOW_PERIOD, s.period);
        cfg_write(CFG_RETUNE_INTERVAL, {12'($urandom), s.interval});
        cfg_write(CFG_MIN_FILL_START, {8'($urandom), s.fill_start});
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        cfg_min_tx     = s.min_tx;
        cfg_base       = s.base;
        cfg_period     = s.period;
        cfg_interval   = s.interval;
        cfg_fill_start = s.fill_start;
        sender_calm    = s.calm;
        if (s.hold_rx)
            rx_hold_req = 1'b1;
    endtask

    // fills cluster around the point where the no-pacing decision flips
    function automatic logic [FILL_W-1:0] pick_fill();
        int v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = FILL_MAX;
            2, 3, 4: v = int'(cfg_min_tx) + int'(pace_target) + $urandom_range(0, 40) - 20;
            default: v = $urandom_range(0, FILL_MAX);
        endcase
        if (v < 0)
            v = 0;
        if (v > FILL_MAX)
            v = FILL_MAX;
        return FILL_W'(v);
    endfunction

    task automatic run_windows(input int quota);
        int sent;
        int npk;
        sent = 0;
        while (sent < quota) begin
            npk = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
            repeat (npk) begin
                send_event(FUNC_PKT_SENT, pick_fill(), 1'b0, '0);
                sent++;
            end
            send_event(FUNC_WIN_DONE, pick_fill(), 1'b0, '0);
            sent++;
            if ($urandom_range(0, 40) == 0)
                wait_quiet();
        end
    endtask

    initial begin : stimulus
        t_settings s;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_PKT_SENT;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_MIN_TX_COUNT;
        i_cfg_wdata   = '0;
        row_typed     = 1'b0;
        row_res       = '0;
        rx_hold_req   = 1'b0;
        sender_calm   = 1'b0;
        burst_left    = 0;
        mismatches    = 0;
        results_seen  = 0;
        pkt_events    = 0;
        win_events    = 0;
        paced_windows = 0;
        free_windows  = 0;
        retunes       = 0;
        rx_holds      = 0;
        i_rst_n       = 1'b0;
        pacing_reset();
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r])
            send_event(dir_rows[r].func, dir_rows[r].fill, dir_rows[r].typed, dir_rows[r].res);
        wait_quiet();

        foreach (sweep_plan[p]) begin
            apply_settings(sweep_plan[p]);
            run_windows(PHASE_ITEMS);
            wait_quiet();
        end

        repeat (3) begin
            s.min_tx     = ($urandom_range(0, 1) != 0) ? FILL_W'($urandom_range(0, 40))
                                                       : FILL_W'($urandom_range(0, FILL_MAX));
            s.base       = FILL_W'($urandom_range(0, FILL_MAX));
            s.period     = PERIOD_W'($urandom_range(1, 16'hFFFF));
            s.interval   = INTERVAL_W'($urandom_range(0, 15));
            s.fill_start = FILL_W'($urandom_range(0, FILL_MAX));
            s.hold_rx    = ($urandom_range(0, 1) == 0);
            s.calm       = ($urandom_range(0, 2) == 0);
            apply_settings(s);
            run_windows(PHASE_ITEMS);
            wait_quiet();
        end

        // zero packet floor, full period, retune on every window
        apply_settings('{8'd0, 8'd5, 16'hFFFF, 4'd0, 8'd255, 1'b0, 1'b1});
        send_event(FUNC_WIN_DONE, 8'd0, 1'b0, '0);
        send_event(FUNC_WIN_DONE, 8'd255, 1'b0, '0);
        run_windows(40);
        wait_quiet();

        $display("covered %0d packet and %0d window events (%0d paced, %0d unpaced, %0d retunes)",
                 pkt_events, win_events, paced_windows, free_windows, retunes);
        $display("%0d results checked, %0d receiver hold-offs, %0d mismatches",
                 results_seen, rx_holds, mismatches);
        if (mismatches == 0 && pending_pace.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
